FILE: hdl/tps_pkg.sv
// tps_pkg: shared types, widths and codes for the triangle plane splitter
// used by every module under hdl; depends on nothing
package tps_pkg;

    // field and datapath widths
    localparam int VW     = 32;   // vertex coordinate, signed fixed point
    localparam int NRMW   = 18;   // plane normal component
    localparam int VPW    = 33;   // vertex minus plane point / edge vector
    localparam int PDW    = 51;   // normal times offset
    localparam int DW     = 53;   // signed distance
    localparam int CPW    = 66;   // edge cross partial product
    localparam int CRW    = 67;   // edge cross component
    localparam int CRSPL  = 34;   // low part of a cross component for the normal product
    localparam int CSW    = 86;   // normal times cross component
    localparam int SUMW   = 88;   // sum of the three normal-cross terms
    localparam int SPLW   = 27;   // low part of a distance for the cut products
    localparam int NUMW   = 88;   // signed cut numerator
    localparam int NMW    = 87;   // cut numerator magnitude
    localparam int DENW   = 54;   // cut denominator magnitude
    localparam int QW     = 32;   // cut quotient magnitude
    localparam int LANES  = 6;    // two cut points, three coordinates each
    localparam int DIV_BPS = 2;   // quotient bits per divider stage

    // configuration port
    localparam int CFGW     = 32;
    localparam int CFG_IDXW = 3;
    localparam logic [CFG_IDXW-1:0] CFG_NX = 3'd0;
    localparam logic [CFG_IDXW-1:0] CFG_NY = 3'd1;
    localparam logic [CFG_IDXW-1:0] CFG_NZ = 3'd2;
    localparam logic [CFG_IDXW-1:0] CFG_PX = 3'd3;
    localparam logic [CFG_IDXW-1:0] CFG_PY = 3'd4;
    localparam logic [CFG_IDXW-1:0] CFG_PZ = 3'd5;

    // piece kinds
    localparam logic [1:0] KIND_UP  = 2'd0;
    localparam logic [1:0] KIND_DN  = 2'd1;
    localparam logic [1:0] KIND_SEG = 2'd2;

    typedef struct packed {
        logic signed [VW-1:0] a_x;
        logic signed [VW-1:0] a_y;
        logic signed [VW-1:0] a_z;
        logic signed [VW-1:0] b_x;
        logic signed [VW-1:0] b_y;
        logic signed [VW-1:0] b_z;
        logic signed [VW-1:0] c_x;
        logic signed [VW-1:0] c_y;
        logic signed [VW-1:0] c_z;
    } t_tri;

    typedef struct packed {
        logic [1:0]           piece_kind;
        logic signed [VW-1:0] p0_x;
        logic signed [VW-1:0] p0_y;
        logic signed [VW-1:0] p0_z;
        logic signed [VW-1:0] p1_x;
        logic signed [VW-1:0] p1_y;
        logic signed [VW-1:0] p1_z;
        logic signed [VW-1:0] p2_x;
        logic signed [VW-1:0] p2_y;
        logic signed [VW-1:0] p2_z;
        logic                 last_piece;
    } t_piece;

    typedef struct packed {
        logic signed [NRMW-1:0] normal_x;
        logic signed [NRMW-1:0] normal_y;
        logic signed [NRMW-1:0] normal_z;
        logic signed [VW-1:0]   plane_x;
        logic signed [VW-1:0]   plane_y;
        logic signed [VW-1:0]   plane_z;
    } t_plane;

    localparam t_plane CFG_RESET = '{
        normal_x: 18'sd0,
        normal_y: 18'sd0,
        normal_z: 18'sd65536,
        plane_x:  32'sd0,
        plane_y:  32'sd0,
        plane_z:  32'sd0
    };

    // per-triangle control and points that ride along with the cut divides
    typedef struct packed {
        logic                        split;
        logic [1:0]                  wkind;
        logic                        up;
        logic [LANES-1:0]            qneg;
        logic [1:0]                  dz;
        logic [2:0][2:0][VW-1:0]     pts;
    } t_side;

endpackage

FILE: hdl/triangle_plane_split.sv
// triangle_plane_split: a triangle passes through tps_front, tps_cut_div, the hold
// register in tps_emit and the result register; one triangle per cycle for whole
// triangles while busy is low; a split one sends four pieces on the single result port: the
// whole pipeline holds while the output stage sends the four pieces, busy is high then.
// Synchronous active-low reset clears all valid bits and loads the default plane.
// The receiver cannot stall; every result is a one-cycle strobe on o_valid.
module triangle_plane_split import tps_pkg::*; #(
    parameter int DIV_BITS_PER_STAGE = DIV_BPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  t_tri                i_tri,
    input  logic                i_cfg_we,
    input  logic [CFG_IDXW-1:0] i_cfg_idx,
    input  logic [CFGW-1:0]     i_cfg_data,
    output logic                o_valid,
    output t_piece              o_piece
);

    t_plane          r_cfg;
    logic            w_adv;
    logic            w_f_vld;
    t_side           w_f_side;
    logic [NMW-1:0]  w_f_num [LANES];
    logic [DENW-1:0] w_f_den [LANES];
    logic            w_d_vld;
    t_side           w_d_side;
    logic [QW-1:0]   w_d_quo [LANES];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NX:  r_cfg.normal_x <= i_cfg_data[NRMW-1:0];
                CFG_NY:  r_cfg.normal_y <= i_cfg_data[NRMW-1:0];
                CFG_NZ:  r_cfg.normal_z <= i_cfg_data[NRMW-1:0];
                CFG_PX:  r_cfg.plane_x  <= i_cfg_data[VW-1:0];
                CFG_PY:  r_cfg.plane_y  <= i_cfg_data[VW-1:0];
                CFG_PZ:  r_cfg.plane_z  <= i_cfg_data[VW-1:0];
                default: ;
            endcase
        end
    end

    // a transfer is taken whenever the pipeline moves
    assign o_busy = !w_adv;

    tps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (i_start),
        .i_tri   (i_tri),
        .i_cfg   (r_cfg),
        .o_vld   (w_f_vld),
        .o_side  (w_f_side),
        .o_num   (w_f_num),
        .o_den   (w_f_den)
    );

    tps_cut_div #(
        .BPS (DIV_BITS_PER_STAGE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_f_vld),
        .i_side  (w_f_side),
        .i_num   (w_f_num),
        .i_den   (w_f_den),
        .o_vld   (w_d_vld),
        .o_side  (w_d_side),
        .o_quo   (w_d_quo)
    );

    tps_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_d_vld),
        .i_side  (w_d_side),
        .i_quo   (w_d_quo),
        .o_adv   (w_adv),
        .o_valid (o_valid),
        .o_piece (o_piece)
    );

endmodule

FILE: hdl/tps_front.sv
// tps_front: distance, classification, apex ordering and cut numerators
// seven register stages; depends on tps_pkg
module tps_front import tps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  t_tri             i_tri,
    input  t_plane           i_cfg,
    output logic             o_vld,
    output t_side            o_side,
    output logic [NMW-1:0]   o_num [LANES],
    output logic [DENW-1:0]  o_den [LANES]
);

    localparam logic [1:0] APEX_A = 2'd0;
    localparam logic [1:0] APEX_B = 2'd1;
    localparam logic [1:0] APEX_C = 2'd2;

    logic signed [VW-1:0]   w_v [3][3];
    logic signed [NRMW-1:0] w_n [3];
    logic signed [VW-1:0]   w_p [3];

    assign w_v[0][0] = i_tri.a_x;
    assign w_v[0][1] = i_tri.a_y;
    assign w_v[0][2] = i_tri.a_z;
    assign w_v[1][0] = i_tri.b_x;
    assign w_v[1][1] = i_tri.b_y;
    assign w_v[1][2] = i_tri.b_z;
    assign w_v[2][0] = i_tri.c_x;
    assign w_v[2][1] = i_tri.c_y;
    assign w_v[2][2] = i_tri.c_z;
    assign w_n[0]    = i_cfg.normal_x;
    assign w_n[1]    = i_cfg.normal_y;
    assign w_n[2]    = i_cfg.normal_z;
    assign w_p[0]    = i_cfg.plane_x;
    assign w_p[1]    = i_cfg.plane_y;
    assign w_p[2]    = i_cfg.plane_z;

    // valid bits, one per stage
    logic [6:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end
    assign o_vld = r_vld[6];

    // stage 1: offsets from the plane point and edge vectors
    logic signed [VW-1:0]  r1_v  [3][3];
    logic signed [VPW-1:0] r1_vp [3][3];
    logic signed [VPW-1:0] r1_e1 [3];
    logic signed [VPW-1:0] r1_e2 [3];
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r1_v[i][k]  <= w_v[i][k];
                    r1_vp[i][k] <= VPW'(w_v[i][k]) - VPW'(w_p[k]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                r1_e1[k] <= VPW'(w_v[1][k]) - VPW'(w_v[0][k]);
                r1_e2[k] <= VPW'(w_v[2][k]) - VPW'(w_v[0][k]);
            end
        end
    end

    // stage 2: distance terms and cross partial products
    logic signed [VW-1:0]  r2_v  [3][3];
    logic signed [PDW-1:0] r2_pd [3][3];
    logic signed [CPW-1:0] r2_cp [6];
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_v[i][k]  <= r1_v[i][k];
                    r2_pd[i][k] <= w_n[k] * r1_vp[i][k];
                end
            end
            r2_cp[0] <= r1_e1[1] * r1_e2[2];
            r2_cp[1] <= r1_e1[2] * r1_e2[1];
            r2_cp[2] <= r1_e1[2] * r1_e2[0];
            r2_cp[3] <= r1_e1[0] * r1_e2[2];
            r2_cp[4] <= r1_e1[0] * r1_e2[1];
            r2_cp[5] <= r1_e1[1] * r1_e2[0];
        end
    end

    // stage 3: distances and cross components
    logic signed [VW-1:0]  r3_v  [3][3];
    logic signed [DW-1:0]  r3_d  [3];
    logic signed [CRW-1:0] r3_cr [3];
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r3_v[i][k] <= r2_v[i][k];
                end
                r3_d[i] <= DW'(r2_pd[i][0]) + DW'(r2_pd[i][1]) + DW'(r2_pd[i][2]);
            end
            for (int k = 0; k < 3; k++) begin
                r3_cr[k] <= CRW'(r2_cp[2*k]) - CRW'(r2_cp[2*k+1]);
            end
        end
    end

    // stage 4: side tests, apex choice and normal-cross partials
    logic [2:0]           w_pos;
    logic [2:0]           w_neg;
    logic                 w_s0ge;
    logic                 w_s1le;
    logic                 w_s2le;
    logic                 w_split;
    logic [1:0]           w_apex;
    logic signed [VW-1:0] w_pa [3][3];
    logic signed [DW-1:0] w_dv;
    logic signed [DW-1:0] w_d1;
    logic signed [DW-1:0] w_d2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pos[i] = r3_d[i] > 0;
            w_neg[i] = r3_d[i][DW-1];
        end
        w_split = (|w_pos) && (|w_neg);
        w_s0ge  = !((w_pos[0] && w_neg[1]) || (w_neg[0] && w_pos[1]));
        w_s1le  = !((w_pos[1] && w_pos[2]) || (w_neg[1] && w_neg[2]));
        w_s2le  = !((w_pos[0] && w_pos[2]) || (w_neg[0] && w_neg[2]));
        if (!w_split) begin
            w_apex = APEX_A;
        end else if (w_s0ge && (w_s1le || w_s2le)) begin
            w_apex = APEX_C;
        end else if (w_s1le) begin
            w_apex = APEX_B;
        end else begin
            w_apex = APEX_A;
        end
    end

    // reorder the vertices so the apex comes first
    always_comb begin
        case (w_apex)
            APEX_C: begin
                for (int k = 0; k < 3; k++) begin
                    w_pa[0][k] = r3_v[2][k];
                    w_pa[1][k] = r3_v[0][k];
                    w_pa[2][k] = r3_v[1][k];
                end
                w_dv = r3_d[2];
                w_d1 = r3_d[0];
                w_d2 = r3_d[1];
            end
            APEX_B: begin
                for (int k = 0; k < 3; k++) begin
                    w_pa[0][k] = r3_v[1][k];
                    w_pa[1][k] = r3_v[2][k];
                    w_pa[2][k] = r3_v[0][k];
                end
                w_dv = r3_d[1];
                w_d1 = r3_d[2];
                w_d2 = r3_d[0];
            end
            default: begin
                for (int k = 0; k < 3; k++) begin
                    w_pa[0][k] = r3_v[0][k];
                    w_pa[1][k] = r3_v[1][k];
                    w_pa[2][k] = r3_v[2][k];
                end
                w_dv = r3_d[0];
                w_d1 = r3_d[1];
                w_d2 = r3_d[2];
            end
        endcase
    end

    logic signed [VW-1:0]         r4_p [3][3];
    logic signed [DW-1:0]         r4_dv;
    logic signed [DW-1:0]         r4_d1;
    logic signed [DW-1:0]         r4_d2;
    logic                         r4_split;
    logic                         r4_copl;
    logic                         r4_allnn;
    logic                         r4_up;
    logic signed [NRMW+CRSPL:0]   r4_sl [3];
    logic signed [PDW-1:0]        r4_sh [3];
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r4_p[i][k] <= w_pa[i][k];
                end
            end
            r4_dv    <= w_dv;
            r4_d1    <= w_d1;
            r4_d2    <= w_d2;
            r4_split <= w_split;
            r4_copl  <= !(|w_pos) && !(|w_neg);
            r4_allnn <= !(|w_neg);
            r4_up    <= w_dv > 0;
            for (int k = 0; k < 3; k++) begin
                r4_sl[k] <= w_n[k] * $signed({1'b0, r3_cr[k][CRSPL-1:0]});
                r4_sh[k] <= w_n[k] * $signed(r3_cr[k][CRW-1:CRSPL]);
            end
        end
    end

    // stage 5: cut numerator partial products, denominators
    logic signed [DW-1:0]     w_dj [2];
    logic signed [DENW-1:0]   w_den [2];
    assign w_dj[0]  = r4_d1;
    assign w_dj[1]  = r4_d2;
    assign w_den[0] = DENW'(r4_dv) - DENW'(r4_d1);
    assign w_den[1] = DENW'(r4_dv) - DENW'(r4_d2);

    logic signed [VW-1:0]        r5_p [3][3];
    logic                        r5_split;
    logic                        r5_copl;
    logic                        r5_allnn;
    logic                        r5_up;
    logic signed [VW+SPLW:0]     r5_alo [2][3];
    logic signed [VW+DW-SPLW-1:0] r5_ahi [2][3];
    logic signed [VW+SPLW:0]     r5_blo [2][3];
    logic signed [VW+DW-SPLW-1:0] r5_bhi [2][3];
    logic [1:0]                  r5_dneg;
    logic [1:0]                  r5_dz;
    logic [DENW-1:0]             r5_dmag [2];
    logic signed [CSW-1:0]       r5_cs [3];
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r5_p[i][k] <= r4_p[i][k];
                end
            end
            r5_split <= r4_split;
            r5_copl  <= r4_copl;
            r5_allnn <= r4_allnn;
            r5_up    <= r4_up;
            for (int j = 0; j < 2; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r5_alo[j][k] <= $signed({1'b0, r4_dv[SPLW-1:0]}) * r4_p[j+1][k];
                    r5_ahi[j][k] <= $signed(r4_dv[DW-1:SPLW]) * r4_p[j+1][k];
                    r5_blo[j][k] <= $signed({1'b0, w_dj[j][SPLW-1:0]}) * r4_p[0][k];
                    r5_bhi[j][k] <= $signed(w_dj[j][DW-1:SPLW]) * r4_p[0][k];
                end
                r5_dneg[j] <= w_den[j][DENW-1];
                r5_dz[j]   <= w_den[j] == '0;
                r5_dmag[j] <= w_den[j][DENW-1] ? DENW'(-w_den[j]) : DENW'(w_den[j]);
            end
            for (int k = 0; k < 3; k++) begin
                r5_cs[k] <= (CSW'(r4_sh[k]) <<< CRSPL) + CSW'(r4_sl[k]);
            end
        end
    end

    // stage 6: signed numerators and the normal-cross sign
    logic signed [VW-1:0]   r6_p [3][3];
    logic                   r6_split;
    logic                   r6_copl;
    logic                   r6_allnn;
    logic                   r6_up;
    logic signed [NUMW-1:0] r6_num [2][3];
    logic [1:0]             r6_dneg;
    logic [1:0]             r6_dz;
    logic [DENW-1:0]        r6_dmag [2];
    logic                   r6_cpos;
    logic signed [SUMW-1:0] w_csum;
    assign w_csum = SUMW'(r5_cs[0]) + SUMW'(r5_cs[1]) + SUMW'(r5_cs[2]);
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r6_p[i][k] <= r5_p[i][k];
                end
            end
            r6_split <= r5_split;
            r6_copl  <= r5_copl;
            r6_allnn <= r5_allnn;
            r6_up    <= r5_up;
            for (int j = 0; j < 2; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r6_num[j][k] <= (NUMW'(r5_ahi[j][k]) <<< SPLW) + NUMW'(r5_alo[j][k])
                                  - (NUMW'(r5_bhi[j][k]) <<< SPLW) - NUMW'(r5_blo[j][k]);
                end
                r6_dmag[j] <= r5_dmag[j];
            end
            r6_dneg <= r5_dneg;
            r6_dz   <= r5_dz;
            r6_cpos <= w_csum > 0;
        end
    end

    // stage 7: magnitudes and quotient signs for the dividers
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int j = 0; j < 2; j++) begin
                for (int k = 0; k < 3; k++) begin
                    o_num[j*3+k] <= r6_num[j][k][NUMW-1] ? NMW'(-r6_num[j][k])
                                                        : NMW'(r6_num[j][k]);
                    o_den[j*3+k]       <= r6_dmag[j];
                    o_side.qneg[j*3+k] <= r6_num[j][k][NUMW-1] ^ r6_dneg[j];
                end
            end
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    o_side.pts[i][k] <= r6_p[i][k];
                end
            end
            o_side.split <= r6_split;
            o_side.up    <= r6_up;
            o_side.dz    <= r6_dz;
            if (r6_copl) begin
                o_side.wkind <= r6_cpos ? KIND_DN : KIND_UP;
            end else begin
                o_side.wkind <= r6_allnn ? KIND_UP : KIND_DN;
            end
        end
    end

endmodule

FILE: hdl/tps_cut_div.sv
// tps_cut_div: pipelined restoring divider, six lanes in lockstep
// carries the triangle sideband along; depends on tps_pkg
module tps_cut_div import tps_pkg::*; #(
    parameter int BPS = DIV_BPS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  t_side            i_side,
    input  logic [NMW-1:0]   i_num [LANES],
    input  logic [DENW-1:0]  i_den [LANES],
    output logic             o_vld,
    output t_side            o_side,
    output logic [QW-1:0]    o_quo [LANES]
);

    localparam int NST = QW / BPS;

    logic            r_vld  [NST];
    t_side           r_side [NST];
    logic [DENW-1:0] r_rem  [NST][LANES];
    logic [DENW-1:0] r_den  [NST][LANES];
    logic [QW-1:0]   r_low  [NST][LANES];
    logic [QW-1:0]   r_quo  [NST][LANES];

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic            a_vld;
        t_side           a_side;
        logic [DENW-1:0] a_rem [LANES];
        logic [DENW-1:0] a_den [LANES];
        logic [QW-1:0]   a_low [LANES];
        logic [QW-1:0]   a_quo [LANES];
        logic [DENW-1:0] n_rem [LANES];
        logic [QW-1:0]   n_low [LANES];
        logic [QW-1:0]   n_quo [LANES];

        // stage inputs: numerator high part seeds the remainder
        if (s == 0) begin : g_head
            always_comb begin
                a_vld  = i_vld;
                a_side = i_side;
                for (int l = 0; l < LANES; l++) begin
                    a_rem[l] = i_num[l][QW+DENW-1:QW];
                    a_low[l] = i_num[l][QW-1:0];
                    a_den[l] = i_den[l];
                    a_quo[l] = '0;
                end
            end
        end else begin : g_body
            always_comb begin
                a_vld  = r_vld[s-1];
                a_side = r_side[s-1];
                for (int l = 0; l < LANES; l++) begin
                    a_rem[l] = r_rem[s-1][l];
                    a_low[l] = r_low[s-1][l];
                    a_den[l] = r_den[s-1][l];
                    a_quo[l] = r_quo[s-1][l];
                end
            end
        end

        // shift-subtract steps of this stage
        always_comb begin : c_step
            logic [DENW:0]   t;
            logic [DENW:0]   diff;
            logic [DENW-1:0] rem;
            logic [QW-1:0]   low;
            logic [QW-1:0]   quo;
            for (int l = 0; l < LANES; l++) begin
                rem = a_rem[l];
                low = a_low[l];
                quo = a_quo[l];
                for (int b = 0; b < BPS; b++) begin
                    t    = {rem, low[QW-1]};
                    low  = {low[QW-2:0], 1'b0};
                    diff = t - {1'b0, a_den[l]};
                    if (t >= {1'b0, a_den[l]}) begin
                        rem = diff[DENW-1:0];
                        quo = {quo[QW-2:0], 1'b1};
                    end else begin
                        rem = t[DENW-1:0];
                        quo = {quo[QW-2:0], 1'b0};
                    end
                end
                n_rem[l] = rem;
                n_low[l] = low;
                n_quo[l] = quo;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_adv) begin
                r_vld[s] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[s] <= a_side;
                for (int l = 0; l < LANES; l++) begin
                    r_rem[s][l] <= n_rem[l];
                    r_low[s][l] <= n_low[l];
                    r_den[s][l] <= a_den[l];
                    r_quo[s][l] <= n_quo[l];
                end
            end
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_side = r_side[NST-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_quo[NST-1][l];
        end
    end

endmodule

FILE: hdl/tps_emit.sv
// tps_emit: holds one finished triangle and sends its pieces one per cycle
// registered result port; depends on tps_pkg
module tps_emit import tps_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  t_side         i_side,
    input  logic [QW-1:0] i_quo [LANES],
    output logic          o_adv,
    output logic          o_valid,
    output t_piece        o_piece
);

    localparam logic [1:0] PC_UPPER = 2'd0;
    localparam logic [1:0] PC_LOW_A = 2'd1;
    localparam logic [1:0] PC_LOW_B = 2'd2;
    localparam logic [1:0] PC_SEG   = 2'd3;

    logic                 r_hv;
    logic [1:0]           r_pc;
    logic                 r_split;
    logic                 r_up;
    logic [1:0]           r_wkind;
    logic signed [VW-1:0] r_pt [3][3];
    logic signed [VW-1:0] r_c1 [3];
    logic signed [VW-1:0] r_c2 [3];
    logic                 r_out_vld;
    t_piece               r_piece;
    logic                 w_last;

    // the hold register frees up on the last piece of its triangle
    assign w_last = !r_split || (r_pc == PC_SEG);
    assign o_adv  = !r_hv || w_last;

    // signed cut points; a zero denominator keeps the apex
    logic signed [VW-1:0] w_cut [2][3];
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 3; k++) begin
                if (i_side.dz[j]) begin
                    w_cut[j][k] = i_side.pts[0][k];
                end else if (i_side.qneg[j*3+k]) begin
                    w_cut[j][k] = -i_quo[j*3+k];
                end else begin
                    w_cut[j][k] = i_quo[j*3+k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_pc <= PC_UPPER;
        end else begin
            if (o_adv) begin
                r_hv <= i_vld;
            end
            if (r_hv) begin
                r_pc <= w_last ? PC_UPPER : r_pc + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_split <= i_side.split;
            r_up    <= i_side.up;
            r_wkind <= i_side.wkind;
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_pt[i][k] <= i_side.pts[i][k];
                end
                r_c1[k] <= w_cut[0][k];
                r_c2[k] <= w_cut[1][k];
            end
        end
    end

    // piece selection
    logic signed [VW-1:0] w_q0 [3];
    logic signed [VW-1:0] w_q1 [3];
    logic signed [VW-1:0] w_q2 [3];
    logic [1:0]           w_kind;
    logic                 w_lastp;
    always_comb begin
        w_kind  = KIND_SEG;
        w_lastp = 1'b1;
        for (int k = 0; k < 3; k++) begin
            w_q0[k] = r_pt[0][k];
            w_q1[k] = r_pt[1][k];
            w_q2[k] = r_pt[2][k];
        end
        if (!r_split) begin
            w_kind = r_wkind;
        end else begin
            case (r_pc)
                PC_UPPER: begin
                    w_kind  = r_up ? KIND_UP : KIND_DN;
                    w_lastp = 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        w_q1[k] = r_c1[k];
                        w_q2[k] = r_c2[k];
                    end
                end
                PC_LOW_A: begin
                    w_kind  = r_up ? KIND_DN : KIND_UP;
                    w_lastp = 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        w_q0[k] = r_c2[k];
                        w_q1[k] = r_c1[k];
                    end
                end
                PC_LOW_B: begin
                    w_kind  = r_up ? KIND_DN : KIND_UP;
                    w_lastp = 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        w_q0[k] = r_c1[k];
                    end
                end
                default: begin
                    w_kind  = KIND_SEG;
                    w_lastp = 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        w_q0[k] = r_up ? r_c1[k] : r_c2[k];
                        w_q1[k] = r_up ? r_c2[k] : r_c1[k];
                        w_q2[k] = '0;
                    end
                end
            endcase
        end
    end

    // result register, one transfer per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_piece.piece_kind <= w_kind;
        r_piece.p0_x       <= w_q0[0];
        r_piece.p0_y       <= w_q0[1];
        r_piece.p0_z       <= w_q0[2];
        r_piece.p1_x       <= w_q1[0];
        r_piece.p1_y       <= w_q1[1];
        r_piece.p1_z       <= w_q1[2];
        r_piece.p2_x       <= w_q2[0];
        r_piece.p2_y       <= w_q2[1];
        r_piece.p2_z       <= w_q2[2];
        r_piece.last_piece <= w_lastp;
    end

    assign o_valid = r_out_vld;
    assign o_piece = r_piece;

endmodule
